>>> rtl/dotr_pkg.sv
// Shared constants, codes and widths for the depth-only triangle rasterizer.
package dotr_pkg;

    localparam int MAX_SIDE_DEF   = 256;
    localparam int DEPTH_BITS_DEF = 24;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DEGEN   = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    localparam int COORD_W = 16;
    localparam int Z_W     = 24;
    localparam int RXY_W   = 8;
    localparam int CNT_W   = 17;

    localparam int PW     = 14;
    localparam int PXW    = PW + 5;
    localparam int EW     = 40;
    localparam int HALF_W = 18;
    localparam int PRODW  = HALF_W + 1 + Z_W;
    localparam int ACC_W  = 64;
    localparam int NUM_W  = ACC_W - 1;
    localparam int DEN_W  = 2 * HALF_W;

endpackage

>>> rtl/depth_only_triangle_raster.sv
// Depth-only triangle rasterizer top level with its depth store, walker and result register.
// Each request yields one result transfer. A read returns the addressed store entry. A clear
// writes one store entry per cycle to all MAX_SIDE*MAX_SIDE entries (65536 by default); the
// same pass runs after reset, and no request is accepted until it ends. A draw runs setup in
// S_SETUP0, S_SETUP1 and S_SETUP2, then walks the clamped bounding box one pixel at a time:
// a pixel outside the triangle is passed over, and a covered pixel takes six steps of the
// shared 18x24 multiply-accumulate and 63 steps of the bit-serial divider that forms the
// interpolated depth, followed by a compare and write-back to the single store memory.
module depth_only_triangle_raster #(
    parameter int MAX_SIDE   = dotr_pkg::MAX_SIDE_DEF,
    parameter int DEPTH_BITS = dotr_pkg::DEPTH_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dotr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dotr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic signed [dotr_pkg::COORD_W-1:0] s_ax,
    input  logic signed [dotr_pkg::COORD_W-1:0] s_ay,
    input  logic signed [dotr_pkg::Z_W-1:0]     s_az,
    input  logic signed [dotr_pkg::COORD_W-1:0] s_bx,
    input  logic signed [dotr_pkg::COORD_W-1:0] s_by_coord,
    input  logic signed [dotr_pkg::Z_W-1:0]     s_bz,
    input  logic signed [dotr_pkg::COORD_W-1:0] s_cx,
    input  logic signed [dotr_pkg::COORD_W-1:0] s_cy,
    input  logic signed [dotr_pkg::Z_W-1:0]     s_cz,
    input  logic [dotr_pkg::RXY_W-1:0]          s_read_x,
    input  logic [dotr_pkg::RXY_W-1:0]          s_read_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dotr_pkg::Z_W-1:0]     m_depth_value,
    output logic [dotr_pkg::CNT_W-1:0]          m_written_count,
    output logic [1:0]                          m_status
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int MW    = dotr_pkg::PW + SW;
    localparam int RW    = dotr_pkg::RXY_W + SW + 1;
    localparam int CW    = dotr_pkg::COORD_W;
    localparam int ZW    = dotr_pkg::Z_W;
    localparam int PW    = dotr_pkg::PW;
    localparam int PXW   = dotr_pkg::PXW;
    localparam int EW    = dotr_pkg::EW;
    localparam int HW    = dotr_pkg::HALF_W;
    localparam int DW    = dotr_pkg::DEN_W;
    localparam int ACW   = dotr_pkg::ACC_W;
    localparam int NW    = dotr_pkg::NUM_W;
    localparam int PRW   = dotr_pkg::PRODW;
    localparam int NTW   = dotr_pkg::CNT_W;
    localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_RST_CLR, S_IDLE, S_SETUP0, S_SETUP1, S_SETUP2, S_PIX, S_MAC,
        S_DIVGO, S_DIV, S_SAT, S_WRITE, S_CLR, S_RD, S_DONE
    } state_t;

    state_t state_reg;

    logic [dotr_pkg::CFG_W-1:0] map_width_reg;
    logic [dotr_pkg::CFG_W-1:0] map_height_reg;
    logic [SW-1:0]              w_eff;
    logic [SW-1:0]              h_eff;

    logic signed [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [ZW-1:0] z_reg [3];

    logic signed [PW-1:0] x0_reg, x1_reg, y0_reg, y1_reg, x_reg, y_reg;
    logic signed [CW:0]   dx_reg [3];
    logic signed [CW:0]   dy_reg [3];
    logic signed [EW-1:0] pa_reg [3];
    logic signed [EW-1:0] pb_reg [3];
    logic signed [EW-1:0] par_a_reg, par_b_reg;
    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] erow_reg [3];
    logic [AW-1:0]        rowbase_reg;
    logic                 neg_reg;
    logic [DW-1:0]        area_abs_reg;
    logic [DW-1:0]        wt_reg [3];
    logic [2:0]           step_reg;
    logic signed [ACW-1:0] acc_reg;
    logic signed [DEPTH_BITS-1:0] qd_reg;
    logic [AW-1:0]        clr_addr_reg;

    logic signed [ZW-1:0] res_depth_reg;
    logic [NTW-1:0]       res_count_reg;
    logic [1:0]           res_status_reg;
    logic                 m_valid_reg;
    logic signed [ZW-1:0] m_depth_reg;
    logic [NTW-1:0]       m_count_reg;
    logic [1:0]           m_status_reg;

    logic signed [PW-1:0]  x0c, x1c, y0c, y1c, wm1, hm1;
    logic signed [PXW-1:0] px0, py0;
    logic signed [CW-1:0]  ox [3];
    logic signed [CW-1:0]  oy [3];
    logic signed [EW-1:0]  sx [3];
    logic signed [EW-1:0]  sy [3];
    logic signed [EW-1:0]  area_c;
    logic                  covered;
    logic                  last_x, last_y, adv_end;
    logic signed [PW-1:0]  adv_x, adv_y;
    logic [AW-1:0]         adv_rowbase;
    logic signed [EW-1:0]  adv_e [3];
    logic signed [EW-1:0]  adv_erow [3];
    logic [AW-1:0]         pix_addr;
    logic [RW-1:0]         rd_lin;
    logic                  rd_out;
    logic [HW-1:0]         half;
    logic signed [PRW-1:0] prod;
    logic signed [ACW-1:0] addend;
    logic signed [ACW-1:0] acc_abs;
    logic signed [ACW-1:0] qmag, qs, qsat;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [DEPTH_BITS-1:0]   ram_wdata, ram_rdata;
    logic                    div_start, div_busy, div_done, div_rem_nz;
    logic [NW-1:0]           div_quo;

    function automatic logic signed [PW-1:0] to_pix(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        t = (CW+1)'(v) + ((v < 0) ? $signed((CW+1)'(15)) : $signed((CW+1)'(0)));
        return PW'(t >>> 4);
    endfunction

    function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a, b, c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a, b, c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    always_comb begin
        w_eff = (map_width_reg == '0) ? SW'(1) :
                (32'(map_width_reg) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(map_width_reg);
        h_eff = (map_height_reg == '0) ? SW'(1) :
                (32'(map_height_reg) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(map_height_reg);
        wm1 = PW'(w_eff) - PW'(1);
        hm1 = PW'(h_eff) - PW'(1);
        x0c = to_pix(min3(ax_reg, bx_reg, cx_reg));
        x1c = to_pix(max3(ax_reg, bx_reg, cx_reg));
        y0c = to_pix(min3(ay_reg, by_reg, cy_reg));
        y1c = to_pix(max3(ay_reg, by_reg, cy_reg));
        if (x0c < 0) begin
            x0c = '0;
        end
        if (y0c < 0) begin
            y0c = '0;
        end
        if (x1c > wm1) begin
            x1c = wm1;
        end
        if (y1c > hm1) begin
            y1c = hm1;
        end
        ox[0] = bx_reg;
        oy[0] = by_reg;
        ox[1] = cx_reg;
        oy[1] = cy_reg;
        ox[2] = ax_reg;
        oy[2] = ay_reg;
        px0 = (PXW'(x0_reg) <<< 4) + PXW'(8);
        py0 = (PXW'(y0_reg) <<< 4) + PXW'(8);
        for (int i = 0; i < 3; i++) begin
            sx[i] = -(EW'(dy_reg[i]) <<< 4);
            sy[i] = EW'(dx_reg[i]) <<< 4;
        end
        area_c = par_a_reg - par_b_reg;
    end

    always_comb begin
        if (neg_reg) begin
            covered = (e_reg[0] <= 0) && (e_reg[1] <= 0) && (e_reg[2] <= 0);
        end else begin
            covered = (e_reg[0] >= 0) && (e_reg[1] >= 0) && (e_reg[2] >= 0);
        end
        last_x      = x_reg == x1_reg;
        last_y      = y_reg == y1_reg;
        adv_end     = last_x && last_y;
        adv_x       = last_x ? x0_reg : x_reg + PW'(1);
        adv_y       = last_x ? y_reg + PW'(1) : y_reg;
        adv_rowbase = last_x ? AW'(rowbase_reg + AW'(w_eff)) : rowbase_reg;
        for (int i = 0; i < 3; i++) begin
            adv_erow[i] = last_x ? erow_reg[i] + sy[i] : erow_reg[i];
            adv_e[i]    = last_x ? erow_reg[i] + sy[i] : e_reg[i] + sx[i];
        end
        pix_addr = AW'(rowbase_reg + AW'(x_reg));
        rd_lin   = RW'(s_read_y) * RW'(w_eff) + RW'(s_read_x);
        rd_out   = (32'(s_read_x) >= 32'(w_eff)) || (32'(s_read_y) >= 32'(h_eff));
    end

    always_comb begin
        half   = step_reg[0] ? wt_reg[step_reg[2:1]][DW-1:HW] : wt_reg[step_reg[2:1]][HW-1:0];
        prod   = PRW'($signed({1'b0, half})) * PRW'(z_reg[step_reg[2:1]]);
        addend = step_reg[0] ? (ACW'(prod) <<< HW) : ACW'(prod);
        acc_abs = (acc_reg < 0) ? -acc_reg : acc_reg;
        qmag   = $signed(ACW'(div_quo));
        qs     = (acc_reg < 0) ? (-qmag - ACW'(div_rem_nz)) : qmag;
        if (qs > ACW'(DMAX)) begin
            qsat = ACW'(DMAX);
        end else if (qs < ACW'(DMIN)) begin
            qsat = ACW'(DMIN);
        end else begin
            qsat = qs;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = qd_reg;
        if (state_reg == S_RST_CLR || state_reg == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = DMAX;
        end else if (state_reg == S_WRITE && qd_reg < $signed(ram_rdata)) begin
            ram_we = 1'b1;
        end
        if (state_reg == S_IDLE) begin
            ram_raddr = AW'(rd_lin);
            ram_re    = s_valid && (s_func == dotr_pkg::FUNC_READ) && !rd_out;
        end else begin
            ram_raddr = pix_addr;
            ram_re    = (state_reg == S_PIX) && covered;
        end
        div_start = state_reg == S_DIVGO;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_RST_CLR;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
            map_width_reg  <= dotr_pkg::CFG_W'(256);
            map_height_reg <= dotr_pkg::CFG_W'(256);
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    dotr_pkg::REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    dotr_pkg::REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                endcase
            end
            if (m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RST_CLR, S_CLR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= (state_reg == S_RST_CLR) ? S_IDLE : S_DONE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        ax_reg         <= s_ax;
                        ay_reg         <= s_ay;
                        bx_reg         <= s_bx;
                        by_reg         <= s_by_coord;
                        cx_reg         <= s_cx;
                        cy_reg         <= s_cy;
                        z_reg[0]       <= s_az;
                        z_reg[1]       <= s_bz;
                        z_reg[2]       <= s_cz;
                        res_depth_reg  <= '0;
                        res_count_reg  <= '0;
                        res_status_reg <= dotr_pkg::STAT_OK;
                        unique case (s_func)
                            dotr_pkg::FUNC_DRAW: state_reg <= S_SETUP0;
                            dotr_pkg::FUNC_READ: begin
                                if (rd_out) begin
                                    res_status_reg <= dotr_pkg::STAT_OUTSIDE;
                                    state_reg      <= S_DONE;
                                end else begin
                                    state_reg <= S_RD;
                                end
                            end
                            dotr_pkg::FUNC_CLEAR: begin
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLR;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RD: begin
                    res_depth_reg <= ZW'($signed(ram_rdata));
                    state_reg     <= S_DONE;
                end
                S_SETUP0: begin
                    x0_reg    <= x0c;
                    x1_reg    <= x1c;
                    y0_reg    <= y0c;
                    y1_reg    <= y1c;
                    dx_reg[0] <= (CW+1)'(cx_reg) - (CW+1)'(bx_reg);
                    dy_reg[0] <= (CW+1)'(cy_reg) - (CW+1)'(by_reg);
                    dx_reg[1] <= (CW+1)'(ax_reg) - (CW+1)'(cx_reg);
                    dy_reg[1] <= (CW+1)'(ay_reg) - (CW+1)'(cy_reg);
                    dx_reg[2] <= (CW+1)'(bx_reg) - (CW+1)'(ax_reg);
                    dy_reg[2] <= (CW+1)'(by_reg) - (CW+1)'(ay_reg);
                    state_reg <= S_SETUP1;
                end
                S_SETUP1: begin
                    for (int i = 0; i < 3; i++) begin
                        pa_reg[i] <= EW'(dx_reg[i]) * EW'(py0 - PXW'(oy[i]));
                        pb_reg[i] <= EW'(dy_reg[i]) * EW'(px0 - PXW'(ox[i]));
                    end
                    par_a_reg   <= EW'(dy_reg[2]) * EW'(dx_reg[1]);
                    par_b_reg   <= EW'(dx_reg[2]) * EW'(dy_reg[1]);
                    rowbase_reg <= AW'(MW'($unsigned(y0_reg)) * MW'(w_eff));
                    state_reg   <= S_SETUP2;
                end
                S_SETUP2: begin
                    for (int i = 0; i < 3; i++) begin
                        e_reg[i]    <= pa_reg[i] - pb_reg[i];
                        erow_reg[i] <= pa_reg[i] - pb_reg[i];
                    end
                    neg_reg      <= area_c < 0;
                    area_abs_reg <= DW'((area_c < 0) ? -area_c : area_c);
                    x_reg        <= x0_reg;
                    y_reg        <= y0_reg;
                    if (area_c == 0) begin
                        res_status_reg <= dotr_pkg::STAT_DEGEN;
                        state_reg      <= S_DONE;
                    end else if (x0_reg > x1_reg || y0_reg > y1_reg) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (covered) begin
                        for (int i = 0; i < 3; i++) begin
                            wt_reg[i] <= DW'(neg_reg ? -e_reg[i] : e_reg[i]);
                        end
                        acc_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_MAC;
                    end else begin
                        x_reg       <= adv_x;
                        y_reg       <= adv_y;
                        rowbase_reg <= adv_rowbase;
                        e_reg       <= adv_e;
                        erow_reg    <= adv_erow;
                        state_reg   <= adv_end ? S_DONE : S_PIX;
                    end
                end
                S_MAC: begin
                    acc_reg  <= acc_reg + addend;
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd5) begin
                        state_reg <= S_DIVGO;
                    end
                end
                S_DIVGO: state_reg <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT: begin
                    qd_reg    <= DEPTH_BITS'(qsat);
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (ram_we) begin
                        res_count_reg <= res_count_reg + NTW'(1);
                    end
                    x_reg       <= adv_x;
                    y_reg       <= adv_y;
                    rowbase_reg <= adv_rowbase;
                    e_reg       <= adv_e;
                    erow_reg    <= adv_erow;
                    state_reg   <= adv_end ? S_DONE : S_PIX;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_depth_reg  <= res_depth_reg;
                        m_count_reg  <= res_count_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    dotr_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dotr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_abs[NW-1:0]),
        .divisor  (area_abs_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    assign s_ready         = state_reg == S_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_depth_value   = m_depth_reg;
    assign m_written_count = m_count_reg;
    assign m_status        = m_status_reg;

    // The divider is only started once the previous quotient has been consumed.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !s_ready)
        else $error("store written while accepting requests");

    a_degen_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == dotr_pkg::STAT_DEGEN) |-> (m_count_reg == '0))
        else $error("degenerate draw reports written pixels");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == dotr_pkg::STAT_OUTSIDE) |-> (m_depth_reg == '0))
        else $error("outside read returns nonzero depth");

endmodule

>>> rtl/dotr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dotr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/dotr_div.sv
// Restoring unsigned divider that resolves one quotient bit per cycle.
module dotr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dotr_pkg::NUM_W-1:0]  dividend,
    input  logic [dotr_pkg::DEN_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [dotr_pkg::NUM_W-1:0]  quotient,
    output logic                        rem_nz
);

    localparam int NW = dotr_pkg::NUM_W;
    localparam int DW = dotr_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   shifted;
    logic          ge;
    logic [DW:0]   rem_next;

    always_comb begin
        shifted  = {rem_reg[DW-1:0], quo_reg[NW-1]};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule
